@@ hdl/imh_pkg.sv @@
// Shared types and codes for the indexed min-heap unit.
// Used by the controller, the datapath and the top level.
package imh_pkg;

  localparam logic [2:0] ACT_LOAD     = 3'd0;
  localparam logic [2:0] ACT_BUILD    = 3'd1;
  localparam logic [2:0] ACT_EXTRACT  = 3'd2;
  localparam logic [2:0] ACT_DECREASE = 3'd3;
  localparam logic [2:0] ACT_QUERY    = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_LOAD, OP_RD_PM, OP_CLR, OP_B_START, OP_MAP_RD, OP_MAP_WR,
    OP_H_INIT, OP_H_START, OP_CUR_LOAD, OP_DEC_I, OP_DEC_CUR, OP_X_RD0, OP_X_RDL,
    OP_X_SW1, OP_X_SW2, OP_RD_L, OP_CAP_L, OP_CAP_R, OP_SW_DN, OP_RD_P, OP_CMP_P,
    OP_WR_CUR, OP_FIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] st;
    logic       is_query;
    logic       is_extract;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       in_range;
    logic       hs_zero;
    logic       ctr_last;
    logic       ctr_eq_cnt;
    logic       ctr_zero;
    logic       pres;
    logic       child_oob;
    logic       best_valid;
    logic       i_zero;
    logic       p_gt;
  } dp_stat_t;

endpackage

@@ hdl/indexed_min_heap_unit.sv @@
// Indexed binary min-heap with decrease-key, one request at a time. Load, out-of-range,
// empty extract and unknown actions go straight to the result; a query reads presence; a
// decrease reads presence (absent: status only); an extract swaps root and last slot; then a
// sift walk runs (down: read left, capture left and right, swap, stop at a leaf; up: read
// parent, compare, stop at the root). Build clears presence, maps slots, sifts down inner slots.
// rst_n (sync, active low) clears presence; requests wait until the clear is done.
module indexed_min_heap_unit import imh_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,     // node_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,      // action[2:0], vertex[12:3], key_value[44:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata      // out_vertex[9:0], out_key[41:10], present[42],
                                     // empty_res[43], status[45:44]
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [9:0]  res_vertex;
  logic [31:0] res_key;
  logic        res_present, res_empty;
  logic [1:0]  res_status;

  assign out_tdata = {2'b00, res_status, res_empty, res_present, res_key, res_vertex};

  imh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .stat(stat), .cmd(cmd)
  );

  imh_datapath #(.MAX_NODES(MAX_NODES), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_action(in_tdata[2:0]), .in_vertex(in_tdata[12:3]), .in_key(in_tdata[44:13]),
    .cmd(cmd), .stat(stat),
    .res_vertex(res_vertex), .res_key(res_key), .res_present(res_present),
    .res_empty(res_empty), .res_status(res_status)
  );

endmodule

@@ hdl/imh_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/imh_datapath.sv @@
// Heap datapath: slot, vertex-map and presence RAMs, index registers, result register.
// Depends on imh_pkg and imh_ram; driven by imh_ctrl commands.
module imh_datapath import imh_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic [2:0]  in_action,
  input  logic [9:0]  in_vertex,
  input  logic [31:0] in_key,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [9:0]  res_vertex,
  output logic [31:0] res_key,
  output logic        res_present,
  output logic        res_empty,
  output logic [1:0]  res_status
);

  localparam int AW   = $clog2(MAX_NODES);
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int EW   = KEY_WIDTH + AW;
  localparam int CHW  = AW + 2;
  localparam int CMPW = (CW > 11) ? CW : 11;
  localparam int VW   = (CW > 10) ? CW : 10;
  localparam logic [CMPW-1:0] MAXN = CMPW'(MAX_NODES);

  logic [10:0]          node_count_r;
  logic [CW-1:0]        hs_r, ctr_r, cnt;
  logic [2:0]           req_act_r;
  logic [9:0]           req_v_r;
  logic [KEY_WIDTH-1:0] req_key_r;
  logic [AW-1:0]        i_r, best_idx_r;
  logic [EW-1:0]        cur_r, best_r, root_r;
  logic                 best_v_r, moved_r;

  logic                 s_we, m_we, p_we, p_wdata, p_rdata;
  logic [AW-1:0]        s_waddr, s_raddr, m_waddr, m_raddr, p_waddr, p_raddr;
  logic [EW-1:0]        s_wdata, s_rdata;
  logic [AW-1:0]        m_wdata, m_rdata;

  logic [CMPW-1:0]      nc_w;
  logic [63:0]          key_ext, root_k64;
  logic [CHW-1:0]       l_w, r_w;
  logic [AW-1:0]        p_w, req_idx;
  logic [KEY_WIDTH-1:0] ref_key;
  logic                 r_in, l_lt, r_lt;

  assign nc_w    = CMPW'(node_count_r);
  assign cnt     = (nc_w > MAXN) ? CW'(MAXN) : CW'(nc_w);
  assign key_ext = 64'($signed(in_key));
  assign req_idx = AW'(req_v_r);
  assign l_w     = CHW'({i_r, 1'b1});
  assign r_w     = l_w + 1'b1;
  assign r_in    = r_w < CHW'(hs_r);
  assign p_w     = AW'((i_r - 1'b1) >> 1);
  assign ref_key = best_v_r ? best_r[EW-1:AW] : cur_r[EW-1:AW];
  assign l_lt    = $signed(s_rdata[EW-1:AW]) < $signed(cur_r[EW-1:AW]);
  assign r_lt    = $signed(s_rdata[EW-1:AW]) < $signed(ref_key);
  assign root_k64 = 64'($signed(root_r[EW-1:AW]));

  always_comb begin
    stat.act        = req_act_r;
    stat.in_range   = VW'(req_v_r) < VW'(cnt);
    stat.hs_zero    = hs_r == '0;
    stat.ctr_last   = ctr_r == CW'(MAX_NODES - 1);
    stat.ctr_eq_cnt = ctr_r == cnt;
    stat.ctr_zero   = ctr_r == '0;
    stat.pres       = p_rdata;
    stat.child_oob  = l_w >= CHW'(hs_r);
    stat.best_valid = best_v_r;
    stat.i_zero     = i_r == '0;
    stat.p_gt       = $signed(s_rdata[EW-1:AW]) > $signed(cur_r[EW-1:AW]);
  end

  always_comb begin
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
    m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = 1'b0; p_raddr = '0;
    case (cmd.op)
      OP_LOAD: begin
        s_we = 1'b1; s_waddr = req_idx; s_wdata = {req_key_r, req_idx};
        m_we = 1'b1; m_waddr = req_idx; m_wdata = req_idx;
      end
      OP_RD_PM: begin
        p_raddr = req_idx; m_raddr = req_idx;
      end
      OP_CLR: begin
        p_we = 1'b1; p_waddr = AW'(ctr_r);
      end
      OP_MAP_RD: s_raddr = AW'(ctr_r);
      OP_MAP_WR: begin
        p_we = 1'b1; p_waddr = s_rdata[AW-1:0]; p_wdata = 1'b1;
        m_we = 1'b1; m_waddr = s_rdata[AW-1:0]; m_wdata = AW'(ctr_r);
      end
      OP_H_START: s_raddr = AW'(ctr_r - 1'b1);
      OP_DEC_I:   s_raddr = m_rdata;
      OP_X_RDL:   s_raddr = AW'(hs_r - 1'b1);
      OP_X_SW1: begin
        s_we = 1'b1; s_waddr = AW'(hs_r - 1'b1); s_wdata = root_r;
        m_we = 1'b1; m_waddr = s_rdata[AW-1:0];
      end
      OP_X_SW2: begin
        m_we = 1'b1; m_waddr = root_r[AW-1:0]; m_wdata = AW'(hs_r - 1'b1);
        p_we = 1'b1; p_waddr = root_r[AW-1:0];
      end
      OP_RD_L:  s_raddr = AW'(l_w);
      OP_CAP_L: s_raddr = AW'(r_w);
      OP_SW_DN: begin
        s_we = 1'b1; s_waddr = i_r; s_wdata = best_r;
        m_we = 1'b1; m_waddr = best_r[AW-1:0]; m_wdata = i_r;
      end
      OP_RD_P: s_raddr = p_w;
      OP_CMP_P: begin
        if (stat.p_gt) begin
          s_we = 1'b1; s_waddr = i_r; s_wdata = s_rdata;
          m_we = 1'b1; m_waddr = s_rdata[AW-1:0]; m_wdata = i_r;
        end
      end
      OP_WR_CUR: begin
        s_we = 1'b1; s_waddr = i_r; s_wdata = cur_r;
        m_we = moved_r; m_waddr = cur_r[AW-1:0]; m_wdata = i_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 11'd1024;
      hs_r         <= '0;
      ctr_r        <= '0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      case (cmd.op)
        OP_CLR:     ctr_r <= stat.ctr_last ? '0 : CW'(ctr_r + 1'b1);
        OP_B_START: begin
          hs_r  <= cnt;
          ctr_r <= '0;
        end
        OP_MAP_WR:  ctr_r <= CW'(ctr_r + 1'b1);
        OP_H_INIT:  ctr_r <= cnt >> 1;
        OP_H_START: ctr_r <= CW'(ctr_r - 1'b1);
        OP_X_SW2:   hs_r  <= CW'(hs_r - 1'b1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        req_act_r <= in_action;
        req_v_r   <= in_vertex;
        req_key_r <= key_ext[KEY_WIDTH-1:0];
      end
      OP_H_START: i_r <= AW'(ctr_r - 1'b1);
      OP_CUR_LOAD: begin
        cur_r   <= s_rdata;
        moved_r <= 1'b0;
      end
      OP_DEC_I: i_r <= m_rdata;
      OP_DEC_CUR: begin
        cur_r   <= {req_key_r, s_rdata[AW-1:0]};
        moved_r <= 1'b0;
      end
      OP_X_RDL: root_r <= s_rdata;
      OP_X_SW1: begin
        cur_r   <= s_rdata;
        i_r     <= '0;
        moved_r <= 1'b0;
      end
      OP_CAP_L: begin
        best_v_r <= l_lt;
        if (l_lt) begin
          best_r     <= s_rdata;
          best_idx_r <= AW'(l_w);
        end
      end
      OP_CAP_R: begin
        if (r_in && r_lt) begin
          best_v_r   <= 1'b1;
          best_r     <= s_rdata;
          best_idx_r <= AW'(r_w);
        end
      end
      OP_SW_DN: begin
        i_r     <= best_idx_r;
        moved_r <= 1'b1;
      end
      OP_CMP_P: begin
        if (stat.p_gt) begin
          i_r     <= p_w;
          moved_r <= 1'b1;
        end
      end
      OP_FIN: begin
        res_vertex  <= cmd.is_extract ? 10'(root_r[AW-1:0]) : 10'd0;
        res_key     <= cmd.is_extract ? root_k64[31:0] : 32'd0;
        res_present <= cmd.is_query & p_rdata;
        res_empty   <= hs_r == '0;
        res_status  <= cmd.st;
      end
      default: ;
    endcase
  end

  imh_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  imh_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_map_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  imh_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_pres_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );

endmodule

@@ hdl/imh_ctrl.sv @@
// Heap controller: sequences load, build, extract, decrease and query requests.
// Depends on imh_pkg; drives imh_datapath through dp_cmd_t.
module imh_ctrl import imh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_RST_CLR, S_IDLE, S_DISP, S_Q_WAIT, S_D_CHK, S_D_CUR, S_X_RDL, S_X_SW1, S_X_SW2,
    S_B_CLR, S_B_MAP_RD, S_B_MAP_WR, S_B_H_NEXT, S_B_H_CUR, S_DN_TEST, S_DN_L, S_DN_R,
    S_DN_SW, S_UP_TEST, S_UP_CMP, S_WR_CUR, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] fin_st_r, fin_st_nxt;
  logic       fin_x_r, fin_x_nxt;
  logic       ret_build_r, ret_build_nxt;
  logic       out_valid_r;
  logic       out_busy;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_busy   = out_valid_r && !out_tready;

  always_comb begin
    state_nxt      = state_r;
    fin_st_nxt     = fin_st_r;
    fin_x_nxt      = fin_x_r;
    ret_build_nxt  = ret_build_r;
    cmd.op         = OP_NOP;
    cmd.st         = ST_OK;
    cmd.is_query   = 1'b0;
    cmd.is_extract = 1'b0;
    unique case (state_r)
      S_RST_CLR: begin
        cmd.op = OP_CLR;
        if (stat.ctr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        fin_st_nxt    = ST_OK;
        fin_x_nxt     = 1'b0;
        ret_build_nxt = 1'b0;
        state_nxt     = S_FIN;
        case (stat.act)
          ACT_LOAD: begin
            if (!stat.in_range) fin_st_nxt = ST_RANGE;
            else cmd.op = OP_LOAD;
          end
          ACT_BUILD: begin
            cmd.op        = OP_B_START;
            ret_build_nxt = 1'b1;
            state_nxt     = S_B_CLR;
          end
          ACT_EXTRACT: begin
            if (stat.hs_zero) fin_st_nxt = ST_EMPTY;
            else begin
              cmd.op    = OP_X_RD0;
              state_nxt = S_X_RDL;
            end
          end
          ACT_DECREASE: begin
            if (!stat.in_range) fin_st_nxt = ST_RANGE;
            else begin
              cmd.op    = OP_RD_PM;
              state_nxt = S_D_CHK;
            end
          end
          ACT_QUERY: begin
            if (!stat.in_range) fin_st_nxt = ST_RANGE;
            else begin
              cmd.op    = OP_RD_PM;
              state_nxt = S_Q_WAIT;
            end
          end
          default: ;
        endcase
      end
      S_Q_WAIT: begin
        if (out_busy) cmd.op = OP_RD_PM;
        else begin
          cmd.op       = OP_FIN;
          cmd.is_query = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_D_CHK: begin
        if (!stat.pres) begin
          fin_st_nxt = ST_ABSENT;
          state_nxt  = S_FIN;
        end else begin
          cmd.op    = OP_DEC_I;
          state_nxt = S_D_CUR;
        end
      end
      S_D_CUR: begin
        cmd.op    = OP_DEC_CUR;
        state_nxt = S_UP_TEST;
      end
      S_X_RDL: begin
        cmd.op    = OP_X_RDL;
        fin_x_nxt = 1'b1;
        state_nxt = S_X_SW1;
      end
      S_X_SW1: begin
        cmd.op    = OP_X_SW1;
        state_nxt = S_X_SW2;
      end
      S_X_SW2: begin
        cmd.op    = OP_X_SW2;
        state_nxt = S_DN_TEST;
      end
      S_B_CLR: begin
        cmd.op = OP_CLR;
        if (stat.ctr_last) state_nxt = S_B_MAP_RD;
      end
      S_B_MAP_RD: begin
        if (stat.ctr_eq_cnt) begin
          cmd.op    = OP_H_INIT;
          state_nxt = S_B_H_NEXT;
        end else begin
          cmd.op    = OP_MAP_RD;
          state_nxt = S_B_MAP_WR;
        end
      end
      S_B_MAP_WR: begin
        cmd.op    = OP_MAP_WR;
        state_nxt = S_B_MAP_RD;
      end
      S_B_H_NEXT: begin
        if (stat.ctr_zero) state_nxt = S_FIN;
        else begin
          cmd.op    = OP_H_START;
          state_nxt = S_B_H_CUR;
        end
      end
      S_B_H_CUR: begin
        cmd.op    = OP_CUR_LOAD;
        state_nxt = S_DN_TEST;
      end
      S_DN_TEST: begin
        if (stat.child_oob) state_nxt = S_WR_CUR;
        else begin
          cmd.op    = OP_RD_L;
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        cmd.op    = OP_CAP_L;
        state_nxt = S_DN_R;
      end
      S_DN_R: begin
        cmd.op    = OP_CAP_R;
        state_nxt = S_DN_SW;
      end
      S_DN_SW: begin
        if (stat.best_valid) begin
          cmd.op    = OP_SW_DN;
          state_nxt = S_DN_TEST;
        end else begin
          state_nxt = S_WR_CUR;
        end
      end
      S_UP_TEST: begin
        if (stat.i_zero) state_nxt = S_WR_CUR;
        else begin
          cmd.op    = OP_RD_P;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.op    = OP_CMP_P;
        state_nxt = stat.p_gt ? S_UP_TEST : S_WR_CUR;
      end
      S_WR_CUR: begin
        cmd.op    = OP_WR_CUR;
        state_nxt = ret_build_r ? S_B_H_NEXT : S_FIN;
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.op         = OP_FIN;
          cmd.st         = fin_st_r;
          cmd.is_extract = fin_x_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RST_CLR;
      fin_st_r    <= ST_OK;
      fin_x_r     <= 1'b0;
      ret_build_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_st_r    <= fin_st_nxt;
      fin_x_r     <= fin_x_nxt;
      ret_build_r <= ret_build_nxt;
      if (cmd.op == OP_FIN) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_fin_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FIN |-> (!out_valid_r || out_tready))
    else $error("result written over a pending one");
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_DISP)
    else $error("accepted request not dispatched");
  a_swap_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_SW_DN |-> stat.best_valid)
    else $error("sift-down swap without a smaller child");
  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FIN |=> state_r == S_IDLE && out_valid_r)
    else $error("finish did not post a result");
`endif

endmodule

@@ verif/imh_checker.sv @@
// Checker for the indexed min-heap unit: predicts each answer from the requests it sees
// and compares the answers on the result channel. Depends on imh_pkg.
module imh_checker import imh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          errors,
  output int          pending
);

  // highest field first, matching out_tdata[45:0]
  typedef struct packed {
    logic [1:0]  status;
    logic        empty;
    logic        present;
    logic [31:0] key;
    logic [9:0]  vtx;
  } heap_answer_t;

  logic signed [31:0] slot_key [1024];
  logic [9:0]         slot_vtx [1024];
  logic [9:0]         vtx_slot [1024];
  bit                 vtx_in   [1024];
  int                 heap_cnt;
  int                 node_cnt;
  heap_answer_t       answer_q[$];

  assign pending = answer_q.size();

  function automatic void swap_entries(int a, int b);
    logic signed [31:0] k;
    logic [9:0] v;
    k = slot_key[a]; v = slot_vtx[a];
    slot_key[a] = slot_key[b]; slot_vtx[a] = slot_vtx[b];
    slot_key[b] = k; slot_vtx[b] = v;
    vtx_slot[slot_vtx[a]] = 10'(a);
    vtx_slot[slot_vtx[b]] = 10'(b);
  endfunction

  function automatic void push_down(int i);
    int l, r, s;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      s = i;
      if (l < heap_cnt && slot_key[l] < slot_key[s]) s = l;
      if (r < heap_cnt && slot_key[r] < slot_key[s]) s = r;
      if (s == i) return;
      swap_entries(i, s);
      i = s;
    end
  endfunction

  function automatic void push_up(int i);
    int p;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (!(slot_key[p] > slot_key[i])) return;
      swap_entries(i, p);
      i = p;
    end
  endfunction

  function automatic heap_answer_t heap_apply(logic [2:0] act, logic [9:0] v,
                                              logic signed [31:0] k);
    heap_answer_t a;
    int cnt, i;
    bit ok_v;
    a = '0;
    cnt = (node_cnt > 1024) ? 1024 : node_cnt;
    ok_v = int'(v) < cnt;
    case (act)
      ACT_LOAD: begin
        if (!ok_v) a.status = ST_RANGE;
        else begin
          slot_key[v] = k; slot_vtx[v] = v; vtx_slot[v] = v;
        end
      end
      ACT_BUILD: begin
        heap_cnt = cnt;
        foreach (vtx_in[j]) vtx_in[j] = 0;
        for (i = 0; i < cnt; i++) begin
          vtx_in[slot_vtx[i]] = 1;
          vtx_slot[slot_vtx[i]] = 10'(i);
        end
        for (i = cnt / 2; i > 0; i--) push_down(i - 1);
      end
      ACT_EXTRACT: begin
        if (heap_cnt == 0) a.status = ST_EMPTY;
        else begin
          a.vtx = slot_vtx[0];
          a.key = slot_key[0];
          swap_entries(0, heap_cnt - 1);
          vtx_in[a.vtx] = 0;
          heap_cnt--;
          push_down(0);
        end
      end
      ACT_DECREASE: begin
        if (!ok_v) a.status = ST_RANGE;
        else if (!vtx_in[v]) a.status = ST_ABSENT;
        else begin
          i = vtx_slot[v];
          slot_key[i] = k;
          push_up(i);
        end
      end
      ACT_QUERY: begin
        if (!ok_v) a.status = ST_RANGE;
        else a.present = vtx_in[v];
      end
      default: ;
    endcase
    a.empty = (heap_cnt == 0);
    return a;
  endfunction

  always @(posedge clk) begin
    heap_answer_t got, want;
    if (!rst_n) begin
      heap_cnt = 0;
      node_cnt = 1024;
      foreach (vtx_in[j]) vtx_in[j] = 0;
      answer_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) node_cnt = int'(cfg_wdata);
      if (in_tvalid && in_tready)
        answer_q.push_back(heap_apply(in_tdata[2:0], in_tdata[12:3], in_tdata[44:13]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[45:0];
        if (answer_q.size() == 0) begin
          $error("unexpected answer %h", out_tdata);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (got.vtx !== want.vtx) begin
            $error("out_vertex exp %0d got %0d", want.vtx, got.vtx); errors++;
          end
          if (got.key !== want.key) begin
            $error("out_key exp %0d got %0d", $signed(want.key), $signed(got.key));
            errors++;
          end
          if (got.present !== want.present) begin
            $error("present exp %0d got %0d", want.present, got.present); errors++;
          end
          if (got.empty !== want.empty) begin
            $error("empty_res exp %0d got %0d", want.empty, got.empty); errors++;
          end
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); errors++;
          end
        end
      end
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the indexed min-heap unit testbench: clock, reset, request stimulus and verdict.
// Depends on imh_pkg, indexed_min_heap_unit and imh_checker.
module testbench;
  import imh_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        in_tvalid, in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;
  int          errors, pending;
  int          send_idle, recv_stall, hold_len;
  int          cycles;
  int          heap_nodes;

  indexed_min_heap_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  imh_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver; a long hold-off is counted here
  always @(posedge clk) begin
    if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send(logic [2:0] act, logic [9:0] v, logic [31:0] k);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b0, k, v, act};
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_nodes(int n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n[10:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    heap_nodes = (n > 1024) ? 1024 : n;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom_range(20) - 10;
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'h7fff_fffc + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] pick_vertex();
    if (heap_nodes == 0 || $urandom_range(19) == 0) return 10'($urandom);
    return 10'($urandom_range(heap_nodes - 1));
  endfunction

  task automatic load_and_build();
    for (int v = 0; v < heap_nodes; v++) send(ACT_LOAD, 10'(v), pick_key());
    send(ACT_BUILD, 10'd0, $urandom);
  endtask

  // without builds the slots above the loaded range are never read
  task automatic random_items(int n, bit with_build = 1'b1);
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < 30)      send(ACT_EXTRACT, 10'($urandom), $urandom);
      else if (r < 55) send(ACT_DECREASE, pick_vertex(), pick_key());
      else if (r < 70) send(ACT_QUERY, pick_vertex(), $urandom);
      else if (r < 82) send(ACT_LOAD, pick_vertex(), pick_key());
      else if (r < 90) begin
        if (with_build) send(ACT_BUILD, 10'($urandom), $urandom);
        else send(ACT_QUERY, pick_vertex(), $urandom);
      end
      else             send(3'($urandom_range(5, 7)), 10'($urandom), $urandom);
    end
  endtask

  initial begin
    cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    hold_len = 0;
    heap_nodes = 1024;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    set_nodes(4);
    send(ACT_EXTRACT, 0, 0);
    send(ACT_QUERY, 1, 0);
    send(ACT_DECREASE, 2, 5);
    send(ACT_LOAD, 1023, 7);
    send(ACT_LOAD, 0, 32'h7fff_ffff);
    send(ACT_LOAD, 1, 32'h8000_0000);
    send(ACT_LOAD, 2, 32'hffff_ffff);
    send(ACT_LOAD, 3, 0);
    send(ACT_BUILD, 0, 0);
    send(ACT_QUERY, 3, 0);
    send(ACT_DECREASE, 0, 32'h8000_0000);
    send(ACT_DECREASE, 3, 32'h7fff_ffff);
    send(ACT_DECREASE, 4, 1);
    send(3'd7, 10'h3ff, 32'hffff_ffff);
    send(ACT_EXTRACT, 0, 0);
    send(ACT_QUERY, 0, 0);
    send(ACT_DECREASE, 0, 3);
    repeat (3) send(ACT_EXTRACT, 0, 0);
    send(ACT_EXTRACT, 0, 0);
    send(ACT_QUERY, 2, 0);

    // random phases
    set_nodes(8);  load_and_build(); random_items(40);
    send_idle = 56;
    set_nodes(1);  load_and_build(); random_items(30);
    send_idle = 0; recv_stall = 56;
    set_nodes(16); load_and_build(); random_items(30);
    hold_len = 300;
    random_items(50);
    drain();
    random_items(30);
    send_idle = 36; recv_stall = 36;
    set_nodes(0);  load_and_build(); random_items(20);
    set_nodes(2047); random_items(40, 1'b0);
    send_idle = 0; recv_stall = 0;
    set_nodes(1024); random_items(30, 1'b0);
    for (int p = 0; p < 4; p++) begin
      send_idle = (p % 2) ? 56 : 0;
      recv_stall = (p > 1) ? 56 : 36;
      set_nodes($urandom_range(2, 32)); load_and_build(); random_items(20);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/imh_pkg.sv
hdl/imh_ram.sv
hdl/imh_datapath.sv
hdl/imh_ctrl.sv
hdl/indexed_min_heap_unit.sv
verif/imh_checker.sv
verif/testbench.sv
